// ===== sv/spq_pkg.sv =====
// ---------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Field widths, request and status codes, and the stored entry format.
// ---------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

   // payload widths
   localparam int VALUE_W  = 32;
   localparam int PRIO_W   = 16;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   // default number of stored entries
   localparam int CAPACITY_DEF = 16;

   // request codes
   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // one stored entry
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [PRIO_W-1:0]         prio;
   } entry_type;

endpackage

`default_nettype wire

// ===== sv/spq_req_if.sv =====
// ---------------------------------------------------------------------------
// spq_req_if: request channel of the sorted priority queue
// Valid/ready handshake carrying an insert or remove request.
// ---------------------------------------------------------------------------
`default_nettype none

interface spq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 func;
   logic signed [spq_pkg::VALUE_W-1:0]   value;
   logic [spq_pkg::PRIO_W-1:0]           priority_req;

   modport source (output valid, output func, output value, output priority_req,
                   input ready);
   modport sink   (input valid, input func, input value, input priority_req,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/spq_rsp_if.sv =====
// ---------------------------------------------------------------------------
// spq_rsp_if: result channel of the sorted priority queue
// Valid/ready handshake carrying status, removed entry and occupancy.
// ---------------------------------------------------------------------------
`default_nettype none

interface spq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [spq_pkg::STATUS_W-1:0]         status;
   logic signed [spq_pkg::VALUE_W-1:0]   out_value;
   logic [spq_pkg::PRIO_W-1:0]           out_priority;
   logic [spq_pkg::OCC_W-1:0]            occupancy;

   modport source (output valid, output status, output out_value,
                   output out_priority, output occupancy, input ready);
   modport sink   (input valid, input status, input out_value,
                   input out_priority, input occupancy, output ready);
endinterface

`default_nettype wire

// ===== sv/sorted_priority_queue_top.sv =====
// Sequence: a remove reads the head entry, then returns it; an empty remove or a full
//   insert answers without touching memory; an insert into an empty queue writes directly;
//   other inserts walk back from the tail past each entry with a larger priority number.
// Throughput: one request at a time; the next is taken
//   the cycle after the result is taken.
// Reset: synchronous; the queue comes out empty, memory contents are not cleared.
// ---------------------------------------------------------------------------
// sorted_priority_queue_top: bounded priority queue kept in sorted order
// Sequencer and entry memory; lower priority number is served first,
// equal priorities leave in arrival order.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_top #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   spq_req_if.sink   req_chan,
   spq_rsp_if.source rsp_chan
);
   import spq_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   entry_type     mem_wdata;
   logic [AW-1:0] mem_raddr;
   entry_type     mem_rdata;

   // sequencer with its compare unit
   spq_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // entry storage
   spq_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

endmodule

`default_nettype wire

// ===== sv/spq_store.sv =====
// ---------------------------------------------------------------------------
// spq_store: entry memory of the sorted priority queue
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module spq_store #(
   parameter int DEPTH = spq_pkg::CAPACITY_DEF,
   parameter int AW    = $clog2(spq_pkg::CAPACITY_DEF)
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [AW-1:0]      wr_addr,
   input  wire spq_pkg::entry_type wr_data,
   input  wire logic [AW-1:0]      rd_addr,
   output spq_pkg::entry_type      rd_data
);
   import spq_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/spq_ctrl.sv =====
// ---------------------------------------------------------------------------
// spq_ctrl: sequencer of the sorted priority queue
// Circular buffer with a head pointer; an insert walks back from the tail,
// moving larger-priority entries up one slot through a single compare unit.
// ---------------------------------------------------------------------------
`default_nettype none

module spq_ctrl #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
   parameter int AW       = $clog2(spq_pkg::CAPACITY_DEF)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   spq_req_if.sink                 req_chan,
   spq_rsp_if.source               rsp_chan,
   output logic                    mem_we,
   output logic [AW-1:0]           mem_waddr,
   output spq_pkg::entry_type      mem_wdata,
   output logic [AW-1:0]           mem_raddr,
   input  wire spq_pkg::entry_type mem_rdata
);
   import spq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
   localparam logic [AW-1:0] LAST_C = AW'(CAPACITY - 1);
   localparam logic [AW:0]   CAPW_C = (AW+1)'(CAPACITY);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_REM_RD  = 6'b000010,
      S_REM_OUT = 6'b000100,
      S_INS_RD  = 6'b001000,
      S_INS_CMP = 6'b010000,
      S_INS_PUT = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       steps_ff, steps_in;
   entry_type           new_ff, new_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [PRIO_W-1:0]   rsp_prio_ff, rsp_prio_in;
   logic [OCC_W-1:0]    rsp_occ_ff, rsp_occ_in;

   logic                req_ready;
   logic [AW:0]         tail_sum;
   logic [AW-1:0]       tail;

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      return (p == LAST_C) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
      return (p == '0) ? LAST_C : p - AW'(1);
   endfunction

   // one request at a time, only with the result register empty
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_chan.ready = req_ready;

   // first free slot behind the last entry
   assign tail_sum = {1'b0, head_ff} + (AW+1)'(count_ff);
   assign tail     = (tail_sum >= CAPW_C) ? AW'(tail_sum - CAPW_C) : tail_sum[AW-1:0];

   // sequencer
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      steps_in      = steps_ff;
      new_in        = new_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_occ_in    = rsp_occ_ff;
      mem_we        = 1'b0;
      mem_waddr     = wr_ptr_ff;
      mem_wdata     = new_ff;
      mem_raddr     = rd_ptr_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid && req_ready) begin
               new_in.value = req_chan.value;
               new_in.prio  = req_chan.priority_req;
               if (func_type'(req_chan.func) == FUNC_REMOVE) begin
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_EMPTY;
                     rsp_value_in  = '0;
                     rsp_prio_in   = '0;
                     rsp_occ_in    = OCC_W'(count_ff);
                  end else begin
                     state_in = S_REM_RD;
                  end
               end else if (count_ff >= CAP_C) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_FULL;
                  rsp_value_in  = '0;
                  rsp_prio_in   = '0;
                  rsp_occ_in    = OCC_W'(count_ff);
               end else if (count_ff == '0) begin
                  wr_ptr_in = head_ff;
                  state_in  = S_INS_PUT;
               end else begin
                  wr_ptr_in = tail;
                  rd_ptr_in = ptr_dec(tail);
                  steps_in  = count_ff;
                  state_in  = S_INS_RD;
               end
            end
         end
         S_REM_RD: begin
            mem_raddr = head_ff;
            state_in  = S_REM_OUT;
         end
         S_REM_OUT: begin
            head_in       = ptr_inc(head_ff);
            count_in      = count_ff - CW'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_DONE;
            rsp_value_in  = mem_rdata.value;
            rsp_prio_in   = mem_rdata.prio;
            rsp_occ_in    = OCC_W'(count_ff - CW'(1));
            state_in      = S_IDLE;
         end
         S_INS_RD: begin
            mem_raddr = rd_ptr_ff;
            state_in  = S_INS_CMP;
         end
         S_INS_CMP: begin
            mem_we = 1'b1;
            if (mem_rdata.prio > new_ff.prio) begin
               // move the larger entry up one slot; walk on, or place the new entry below it
               mem_wdata = mem_rdata;
               wr_ptr_in = rd_ptr_ff;
               rd_ptr_in = ptr_dec(rd_ptr_ff);
               steps_in  = steps_ff - CW'(1);
               state_in  = (steps_ff == CW'(1)) ? S_INS_PUT : S_INS_RD;
            end else begin
               count_in      = count_ff + CW'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_DONE;
               rsp_value_in  = '0;
               rsp_prio_in   = '0;
               rsp_occ_in    = OCC_W'(count_ff + CW'(1));
               state_in      = S_IDLE;
            end
         end
         S_INS_PUT: begin
            mem_we        = 1'b1;
            count_in      = count_ff + CW'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_DONE;
            rsp_value_in  = '0;
            rsp_prio_in   = '0;
            rsp_occ_in    = OCC_W'(count_ff + CW'(1));
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      wr_ptr_ff     <= wr_ptr_in;
      rd_ptr_ff     <= rd_ptr_in;
      steps_ff      <= steps_in;
      new_ff        <= new_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.out_value    = rsp_value_ff;
   assign rsp_chan.out_priority = rsp_prio_ff;
   assign rsp_chan.occupancy    = rsp_occ_ff;

endmodule

`default_nettype wire

// ===== sv/spq_checker.sv =====
// ---------------------------------------------------------------------------
// spq_checker: port-level checks of the sorted priority queue
// Watches the request and result channels over time; bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module spq_checker #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [spq_pkg::STATUS_W-1:0]  rsp_status,
   input wire logic [spq_pkg::VALUE_W-1:0]   rsp_out_value,
   input wire logic [spq_pkg::PRIO_W-1:0]    rsp_out_priority,
   input wire logic [spq_pkg::OCC_W-1:0]     rsp_occupancy
);
   import spq_pkg::*;

   // a request is only taken with no result outstanding
   a_ready_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("request ready while a result is pending");

   // one request in flight: not ready right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in progress");

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_value) && $stable(rsp_out_priority)
         && $stable(rsp_occupancy)))
      else $error("result changed while stalled");

   // empty and full reports carry no entry; full reports the capacity
   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_EMPTY || rsp_status == ST_FULL))
         |-> (rsp_out_value == '0 && rsp_out_priority == '0))
      else $error("error result carries entry data");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_occupancy == OCC_W'(CAPACITY)))
      else $error("full result with wrong occupancy");

endmodule

bind sorted_priority_queue_top spq_checker #(
   .CAPACITY (CAPACITY)
) u_spq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_status       (rsp_chan.status),
   .rsp_out_value    (rsp_chan.out_value),
   .rsp_out_priority (rsp_chan.out_priority),
   .rsp_occupancy    (rsp_chan.occupancy)
);

`default_nettype wire
